[rtl/q2e_pkg.sv]
// Shared types, widths, constants and helper functions for the quaternion to Euler core.
package q2e_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = DATA_WIDTH - 1;
  localparam int PROD_W       = DATA_WIDTH + 1;
  localparam int Q_W          = DATA_WIDTH + 3;
  localparam int ROOT_W       = 2 * PROD_W;
  localparam int WORK_FRAC    = 40;
  localparam int SCALE_SH     = WORK_FRAC - FRAC_BITS;
  localparam int CW           = 48;
  localparam int AW           = 34;
  localparam int ANGLE_W      = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NLANES       = 3;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } q2e_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      pitch_clamped;
  } q2e_res_t;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } q2e_lane_t;

  typedef struct packed {
    logic                        valid;
    logic                        clamped;
    q2e_lane_t [NLANES-1:0]      lane;
  } q2e_stage_t;

  // Arctangent of 2^-idx in 32-bit binary angle units, zero extended.
  function automatic logic signed [AW-1:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return {{(AW-32){1'b0}}, v};
  endfunction

  // Exact product of two Q.F values, floored back to F fraction bits.
  function automatic logic signed [PROD_W-1:0] prod_f(input logic signed [DATA_WIDTH-1:0] a,
                                                      input logic signed [DATA_WIDTH-1:0] b);
    logic signed [2*DATA_WIDTH-1:0] full;
    full = a * b;
    return full[2*DATA_WIDTH-1:DATA_WIDTH-1];
  endfunction

  // Moves a Q.F value to the working fraction width of the CORDIC.
  function automatic logic signed [CW-1:0] scale_q(input logic signed [Q_W-1:0] v);
    logic signed [CW-1:0] ext;
    ext = CW'(v);
    return ext <<< SCALE_SH;
  endfunction

  // Builds the CORDIC start vector; a negative x is first turned by a quarter turn.
  function automatic q2e_lane_t prerot(input logic signed [Q_W-1:0] yv,
                                       input logic signed [Q_W-1:0] xv);
    q2e_lane_t l;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = scale_q(xv);
    ys = scale_q(yv);
    l.zero = (xv == '0) && (yv == '0);
    l.x    = xs;
    l.y    = ys;
    l.ang  = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        l.x   = ys;
        l.y   = -xs;
        l.ang = AW'(34'sd1 <<< 30);
      end else begin
        l.x   = -ys;
        l.y   = xs;
        l.ang = -AW'(34'sd1 <<< 30);
      end
    end
    return l;
  endfunction

  // Rounds a 32-bit binary angle to 16-bit units, kept at 18 bits before wrapping.
  function automatic logic signed [AW-17:0] round_ang(input q2e_lane_t l);
    logic signed [AW-1:0] t;
    t = l.ang + AW'(32768);
    if (l.zero) begin
      t = '0;
    end
    return t[AW-1:16];
  endfunction

endpackage

[rtl/q2e_sqrt_cell.sv]
// One cell of the pipelined integer square root: settles one result bit per cycle.
module q2e_sqrt_cell #(
  parameter int K      = 0,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [q2e_pkg::ROOT_W-1:0]   rem_i,
  input  logic [q2e_pkg::ROOT_W-1:0]   root_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [q2e_pkg::ROOT_W-1:0]   rem_o,
  output logic [q2e_pkg::ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]            side_o
);
  import q2e_pkg::*;

  localparam logic [ROOT_W-1:0] Bit = ROOT_W'(1) << (2 * K);

  logic              valid_q;
  logic [ROOT_W-1:0] rem_d, rem_q, root_d, root_q, trial;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    trial = root_i + Bit;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

[rtl/q2e_cordic_cell.sv]
// One vectoring CORDIC iteration for the three angle lanes, registered.
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  q2e_pkg::q2e_stage_t  stage_i,
  output q2e_pkg::q2e_stage_t  stage_o
);
  import q2e_pkg::*;

  localparam logic signed [AW-1:0] Atan = atan_entry(IDX);

  q2e_stage_t stage_d, stage_q;
  logic       valid_q;
  logic signed [CW-1:0] dx [NLANES];
  logic signed [CW-1:0] dy [NLANES];

  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < NLANES; l++) begin
      dx[l] = $signed(stage_i.lane[l].y) >>> IDX;
      dy[l] = $signed(stage_i.lane[l].x) >>> IDX;
      if ($signed(stage_i.lane[l].y) > 0) begin
        stage_d.lane[l].x   = stage_i.lane[l].x + dx[l];
        stage_d.lane[l].y   = stage_i.lane[l].y - dy[l];
        stage_d.lane[l].ang = stage_i.lane[l].ang + Atan;
      end else begin
        stage_d.lane[l].x   = stage_i.lane[l].x - dx[l];
        stage_d.lane[l].y   = stage_i.lane[l].y + dy[l];
        stage_d.lane[l].ang = stage_i.lane[l].ang - Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

[rtl/quaternion_to_euler_core.sv]
// Top level of the quaternion to ZYX Euler angle converter.
// The pipeline holds four front stages, one square root cell per result bit,
// one pre-rotation stage, one CORDIC cell per iteration and the output register.
// Throughput: one request per cycle; busy is never raised and the result strobe cannot stall.
// Reset clears only the valid bits of the pipeline; data registers are left as they are.
module quaternion_to_euler_core #(
  parameter int CordicSteps = q2e_pkg::CORDIC_STEPS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  q2e_pkg::q2e_req_t req_i,
  output logic              valid_o,
  output q2e_pkg::q2e_res_t res_o
);
  import q2e_pkg::*;

  // The sidecar carries the roll and yaw operands, the arcsine argument and the
  // clamp flag through the square root cells so that all three lanes stay aligned.
  localparam int SideW   = 4 * Q_W + PROD_W + 1;
  localparam int SqCells = FRAC_BITS + 1;
  localparam int Latency = DATA_WIDTH + CordicSteps + 6;

  localparam logic signed [Q_W-1:0]    One   = Q_W'(1) <<< FRAC_BITS;
  localparam logic signed [AW-17:0]    PMax  = (AW-16)'(16384);

  // The block never holds off a request.
  assign busy = 1'b0;

  // Stage 1: capture the request.
  logic     v1_q;
  q2e_req_t q1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q <= req_i;
  end

  // Stage 2: the nine products, each floored back to F fraction bits.
  logic v2_q;
  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q <= prod_f(q1_q.quat_w, q1_q.quat_x);
    yz_q <= prod_f(q1_q.quat_y, q1_q.quat_z);
    xx_q <= prod_f(q1_q.quat_x, q1_q.quat_x);
    yy_q <= prod_f(q1_q.quat_y, q1_q.quat_y);
    wy_q <= prod_f(q1_q.quat_w, q1_q.quat_y);
    zx_q <= prod_f(q1_q.quat_z, q1_q.quat_x);
    wz_q <= prod_f(q1_q.quat_w, q1_q.quat_z);
    xy_q <= prod_f(q1_q.quat_x, q1_q.quat_y);
    zz_q <= prod_f(q1_q.quat_z, q1_q.quat_z);
  end

  // Stage 3: the atan2 operands, and the arcsine argument saturated to one in magnitude.
  logic v3_q;
  logic signed [Q_W-1:0]    ry_d, rx_d, yn_d, yx_d, s_raw;
  logic signed [Q_W-1:0]    ry_q, rx_q, yn_q, yx_q;
  logic signed [PROD_W-1:0] s_d, s_q;
  logic                     cl_d, cl_q;

  always_comb begin
    ry_d  = (Q_W'(wx_q) + Q_W'(yz_q)) <<< 1;
    rx_d  = One - ((Q_W'(xx_q) + Q_W'(yy_q)) <<< 1);
    yn_d  = (Q_W'(wz_q) + Q_W'(xy_q)) <<< 1;
    yx_d  = One - ((Q_W'(yy_q) + Q_W'(zz_q)) <<< 1);
    s_raw = (Q_W'(wy_q) - Q_W'(zx_q)) <<< 1;
    cl_d  = 1'b0;
    s_d   = PROD_W'(s_raw);
    if (s_raw > One) begin
      s_d  = PROD_W'(One);
      cl_d = 1'b1;
    end else if (s_raw < -One) begin
      s_d  = PROD_W'(-One);
      cl_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ry_q  <= ry_d;
    rx_q  <= rx_d;
    yn_q  <= yn_d;
    yx_q  <= yx_d;
    s_q   <= s_d;
    cl_q  <= cl_d;
  end

  // Stage 4: the radicand 1 - s^2 at 2F fraction bits.
  logic v4_q;
  logic signed [ROOT_W-1:0] sq;
  logic [ROOT_W-1:0]        rad_q;
  logic [SideW-1:0]         side4_q;

  assign sq = s_q * s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= (ROOT_W'(1) << (2 * FRAC_BITS)) - ROOT_W'(sq);
    side4_q <= {ry_q, rx_q, yn_q, yx_q, s_q, cl_q};
  end

  // Square root cells, most significant result bit first.
  logic              sv   [SqCells+1];
  logic [ROOT_W-1:0] srem [SqCells+1];
  logic [ROOT_W-1:0] sroot[SqCells+1];
  logic [SideW-1:0]  sside[SqCells+1];

  assign sv[0]    = v4_q;
  assign srem[0]  = rad_q;
  assign sroot[0] = '0;
  assign sside[0] = side4_q;

  for (genvar j = 0; j < SqCells; j++) begin : g_sqrt
    q2e_sqrt_cell #(
      .K      (FRAC_BITS - j),
      .SIDE_W (SideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[j]),
      .rem_i   (srem[j]),
      .root_i  (sroot[j]),
      .side_i  (sside[j]),
      .valid_o (sv[j+1]),
      .rem_o   (srem[j+1]),
      .root_o  (sroot[j+1]),
      .side_o  (sside[j+1])
    );
  end

  // Pre-rotation stage: scale the three operand pairs and fold a negative x.
  logic signed [Q_W-1:0]    e_ry, e_rx, e_yy, e_yx;
  logic signed [PROD_W-1:0] e_s;
  logic                     e_cl;
  logic signed [Q_W-1:0]    e_c;
  q2e_stage_t               pre_d, pre_q;
  logic                     pre_v_q;
  q2e_stage_t               chain[CordicSteps+1];

  always_comb begin
    {e_ry, e_rx, e_yy, e_yx, e_s, e_cl} = sside[SqCells];
    e_c   = Q_W'(sroot[SqCells][PROD_W-1:0]);
    pre_d.valid            = sv[SqCells];
    pre_d.clamped          = e_cl;
    pre_d.lane[LANE_ROLL]  = prerot(e_ry, e_rx);
    pre_d.lane[LANE_PITCH] = prerot(Q_W'(e_s), e_c);
    pre_d.lane[LANE_YAW]   = prerot(e_yy, e_yx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else begin
      pre_v_q <= pre_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  always_comb begin
    chain[0]       = pre_q;
    chain[0].valid = pre_v_q;
  end

  // CORDIC cells, one iteration each.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    q2e_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // Output stage: round to 16-bit binary angles and hold pitch within a quarter turn.
  logic signed [AW-17:0] r_roll, r_pitch, r_yaw;
  q2e_res_t              res_d, res_q;
  logic                  vo_q;

  always_comb begin
    r_roll  = round_ang(chain[CordicSteps].lane[LANE_ROLL]);
    r_pitch = round_ang(chain[CordicSteps].lane[LANE_PITCH]);
    r_yaw   = round_ang(chain[CordicSteps].lane[LANE_YAW]);
    if (r_pitch > PMax) begin
      r_pitch = PMax;
    end else if (r_pitch < -PMax) begin
      r_pitch = -PMax;
    end
    res_d.roll_angle    = r_roll[ANGLE_W-1:0];
    res_d.pitch_angle   = r_pitch[ANGLE_W-1:0];
    res_d.yaw_angle     = r_yaw[ANGLE_W-1:0];
    res_d.pitch_clamped = chain[CordicSteps].clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= chain[CordicSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

  // A result strobe follows exactly one accepted request.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, Latency))
    else $error("result strobe without a matching request");

  a_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency valid_o)
    else $error("accepted request produced no result");

  // Pitch never leaves the quarter turn on either side.
  a_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(res_o.pitch_angle) <= 16'sd16384 &&
                 $signed(res_o.pitch_angle) >= -16'sd16384))
    else $error("pitch outside a quarter turn");

endmodule

[bench/tb_quaternion_to_euler_core.sv]
// Self-checking testbench for the quaternion to Euler angle core.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_core;
  import q2e_pkg::*;

  // The core computes the same pipeline depth in its Latency parameter.
  // The drain wait at the end and the watchdog limit are derived from it.
  localparam int PIPE_DEPTH   = DATA_WIDTH + CORDIC_STEPS + 6;
  localparam int STALL_LIMIT  = 20 * PIPE_DEPTH + 200;
  localparam int RANDOM_ITEMS = 450;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  q2e_req_t req_i;
  logic     valid_o;
  q2e_res_t res_o;

  quaternion_to_euler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Arctangent of 2^-i in binary units where 2^31 stands for pi.
  localparam longint ARCTAN_LUT [TABLE_LEN] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  // Product of two fixed point values, floored back to FRAC_BITS fraction bits.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // Integer square root rounded down.
  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  // Vectoring CORDIC arctangent; angle in 32-bit binary units.
  function automatic longint vector_angle(longint yv, longint xv);
    longint acc;
    longint t;
    longint dx;
    longint dy;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    xv = xv <<< (WORK_FRAC - FRAC_BITS);
    yv = yv <<< (WORK_FRAC - FRAC_BITS);
    // A vector in the left half plane is turned a quarter turn first.
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; acc = 64'sd1 <<< 30;
      end else begin
        t = xv; xv = -yv; yv = t; acc = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv = xv + dx; yv = yv - dy; acc = acc + ARCTAN_LUT[i];
      end else begin
        xv = xv - dx; yv = yv + dy; acc = acc - ARCTAN_LUT[i];
      end
    end
    return acc;
  endfunction

  function automatic longint to_binary_angle(longint a32);
    return (a32 + 32768) >>> 16;
  endfunction

  // Computes the Euler angles that the core should return for one quaternion.
  function automatic q2e_res_t euler_of(q2e_req_t q);
    longint w, x, y, z, one, num, den, s, c, p;
    q2e_res_t r;
    w   = longint'(q.quat_w);
    x   = longint'(q.quat_x);
    y   = longint'(q.quat_y);
    z   = longint'(q.quat_z);
    one = 64'sd1 <<< FRAC_BITS;
    r.pitch_clamped = 1'b0;

    num = 2 * (fx_mul(w, x) + fx_mul(y, z));
    den = one - 2 * (fx_mul(x, x) + fx_mul(y, y));
    r.roll_angle = ANGLE_W'(to_binary_angle(vector_angle(num, den)));

    // The arcsine argument is saturated to unit magnitude and flagged.
    s = 2 * (fx_mul(w, y) - fx_mul(z, x));
    if (s > one) begin
      s = one; r.pitch_clamped = 1'b1;
    end else if (s < -one) begin
      s = -one; r.pitch_clamped = 1'b1;
    end
    c = floor_sqrt(longint'(one * one - s * s));
    p = to_binary_angle(vector_angle(s, c));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    r.pitch_angle = ANGLE_W'(p);

    num = 2 * (fx_mul(w, z) + fx_mul(x, y));
    den = one - 2 * (fx_mul(y, y) + fx_mul(z, z));
    r.yaw_angle = ANGLE_W'(to_binary_angle(vector_angle(num, den)));
    return r;
  endfunction

  // Directed rows. Where the clamp flag is obvious from the inputs it is typed in;
  // the angles always come from the predictor.
  typedef struct {
    q2e_req_t q;
    bit       flag_known;
    bit       flag;
  } quat_case_t;

  quat_case_t directed [$];
  q2e_res_t   pending_angles [$];
  int         mismatches;
  int         requests_sent;
  int         results_seen;
  int         idle_cycles;
  int         clamp_seen;
  bit         accepted_now;

  function automatic quat_case_t mk(int w, int x, int y, int z, bit known, bit fl);
    quat_case_t c;
    c.q.quat_w = 16'(w); c.q.quat_x = 16'(x);
    c.q.quat_y = 16'(y); c.q.quat_z = 16'(z);
    c.flag_known = known;
    c.flag = fl;
    return c;
  endfunction

  // Sends one request; start stays high so back to back requests need no toggle.
  task automatic send_quat(q2e_req_t q, bit known, bit fl);
    q2e_res_t e;
    start <= 1'b1;
    req_i <= q;
    @(negedge clk_i);
    while (busy) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    e = euler_of(q);
    if (known) e.pitch_clamped = fl;
    pending_angles.push_back(e);
    requests_sent++;
    accepted_now = 1'b1;
    @(posedge clk_i);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // A roughly unit quaternion, sometimes scaled slightly past unit length, or random bits when unit_len is clear.
  function automatic q2e_req_t random_quat(bit unit_len);
    real c[4];
    real norm;
    real gain;
    q2e_req_t q;
    if (!unit_len) begin
      q = q2e_req_t'({$urandom, $urandom});
      return q;
    end
    do begin
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
        c[i] = real'(int'($urandom_range(65535)) - 32768);
        norm = norm + c[i] * c[i];
      end
    end while (norm < 1.0);
    norm = $sqrt(norm);
    gain = ($urandom_range(9) == 0) ? 1.0 + real'($urandom_range(30)) / 100.0 : 1.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = c[i] / norm * 32767.0 * gain;
      if (c[i] > 32767.0) c[i] = 32767.0;
      if (c[i] < -32768.0) c[i] = -32768.0;
    end
    q.quat_w = 16'($rtoi(c[0])); q.quat_x = 16'($rtoi(c[1]));
    q.quat_y = 16'($rtoi(c[2])); q.quat_z = 16'($rtoi(c[3]));
    return q;
  endfunction

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(6))
      0: return 16'sd0;
      1: return 16'sd32767;
      2: return -16'sd32768;
      3: return -16'sd32767;
      4: return 16'sd1;
      5: return -16'sd1;
      default: return 16'sd23170;
    endcase
  endfunction

  // Results are sampled mid-cycle, away from the edge where the core updates them.
  always @(negedge clk_i) begin
    q2e_res_t e;
    if (rst_ni) begin
      if (valid_o) begin
        results_seen++;
        if (res_o.pitch_clamped) clamp_seen++;
        if (pending_angles.size() == 0) begin
          $error("unexpected result strobe, roll %0d pitch %0d yaw %0d",
                 res_o.roll_angle, res_o.pitch_angle, res_o.yaw_angle);
          mismatches++;
        end else begin
          e = pending_angles.pop_front();
          if (res_o.roll_angle !== e.roll_angle) begin
            $error("roll_angle expected %0d got %0d", e.roll_angle, res_o.roll_angle);
            mismatches++;
          end
          if (res_o.pitch_angle !== e.pitch_angle) begin
            $error("pitch_angle expected %0d got %0d", e.pitch_angle, res_o.pitch_angle);
            mismatches++;
          end
          if (res_o.yaw_angle !== e.yaw_angle) begin
            $error("yaw_angle expected %0d got %0d", e.yaw_angle, res_o.yaw_angle);
            mismatches++;
          end
          if (res_o.pitch_clamped !== e.pitch_clamped) begin
            $error("pitch_clamped expected %0b got %0b", e.pitch_clamped, res_o.pitch_clamped);
            mismatches++;
          end
        end
      end
      // The watchdog counts cycles in which neither a request nor a result moves.
      if (valid_o || accepted_now) idle_cycles = 0;
      else idle_cycles++;
      accepted_now = 1'b0;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_angles.size());
        $display("[quaternion_to_euler_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    int done;
    q2e_req_t q;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    mismatches = 0;
    requests_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    clamp_seen = 0;
    accepted_now = 1'b0;

    // Identity, zero and extreme components.
    directed.push_back(mk(32767, 0, 0, 0, 1, 0));
    directed.push_back(mk(0, 0, 0, 0, 1, 0));
    directed.push_back(mk(-32768, 0, 0, 0, 1, 0));
    directed.push_back(mk(0, 32767, 0, 0, 1, 0));
    directed.push_back(mk(0, 0, 32767, 0, 0, 0));
    directed.push_back(mk(0, 0, 0, 32767, 1, 0));
    directed.push_back(mk(-32768, -32768, -32768, -32768, 0, 0));
    directed.push_back(mk(32767, 32767, 32767, 32767, 0, 0));
    // Arcsine argument past unit magnitude, both signs.
    directed.push_back(mk(32767, 0, 32767, 0, 1, 1));
    directed.push_back(mk(-32768, 0, -32768, 0, 1, 1));
    directed.push_back(mk(32767, 0, -32768, 0, 1, 1));
    directed.push_back(mk(0, 32767, 0, 32767, 1, 1));
    // Pitch at plus and minus a quarter turn for a unit quaternion.
    directed.push_back(mk(23170, 0, 23170, 0, 0, 0));
    directed.push_back(mk(23170, 0, -23170, 0, 0, 0));
    // An atan2 on the negative x axis, roll in the first row and yaw in the second: each gives plus pi.
    directed.push_back(mk(0, 32767, 32767, 0, 0, 0));
    directed.push_back(mk(0, 0, 32767, 32767, 0, 0));
    // Components chosen so that an atan2 has one or both operands near zero.
    directed.push_back(mk(0, 23170, 0, 0, 0, 0));
    directed.push_back(mk(0, 0, 0, 23170, 0, 0));
    directed.push_back(mk(16384, 16384, 16384, 16384, 0, 0));
    directed.push_back(mk(-16384, 16384, -16384, 16384, 0, 0));
    directed.push_back(mk(1, -1, 1, -1, 0, 0));
    directed.push_back(mk(-1, 1, -1, 1, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_quat(directed[i].q, directed[i].flag_known, directed[i].flag);
      idle_for((i % 3 == 0) ? 0 : $urandom_range(3));
    end

    // Random bursts with random gaps; some stretches run back to back.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && done < RANDOM_ITEMS; k++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4:
            q = random_quat(1'b0);
          5, 6:
            q = '{corner_value(), corner_value(), corner_value(), corner_value()};
          default:
            q = random_quat(1'b1);
        endcase
        send_quat(q, 1'b0, 1'b0);
        done++;
        // Hold off once mid-run until the pipeline has drained completely.
        if (done == RANDOM_ITEMS / 2) begin
          start <= 1'b0;
          while (pending_angles.size() != 0) @(posedge clk_i);
        end
      end
      idle_for(($urandom_range(3) == 0) ? 0 : $urandom_range(1, PIPE_DEPTH + 4));
    end
    start <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);

    $display("Sent %0d quaternions (%0d directed), checked %0d Euler results, %0d clamped.",
             requests_sent, directed.size(), results_seen, clamp_seen);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("[quaternion_to_euler_core] OK");
    end else begin
      $display("[quaternion_to_euler_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/q2e_pkg.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_core.sv
bench/tb_quaternion_to_euler_core.sv
